FILE: hw/rtl/ptm_pkg.sv
// Shared types, constants and lookup functions for the pinyin tone-mark converter.
package ptm_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int CHAR_W            = 16;
  localparam int OUT_POS_W         = 32;
  localparam int S_DATA_W          = 16;
  localparam int M_DATA_W          = 80;

  localparam logic [3:0] NO_VOWEL = 4'd12;

  typedef enum logic [1:0] {
    PAIR_NONE   = 2'd0,
    PAIR_FIRST  = 2'd1,
    PAIR_SECOND = 2'd2
  } pair_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ONE   = 4'b0010,
    ST_TWO   = 4'b0100,
    ST_THREE = 4'b1000
  } stage_e;

  typedef struct packed {
    logic [OUT_POS_W-1:0] remove_position;
    logic [CHAR_W-1:0]    toned_char;
    logic [OUT_POS_W-1:0] replace_position;
  } ptm_result_t;

  // rows: a o e i u v (lower), A O E I U V (upper); columns: tone 0..4
  localparam logic [15:0] TONE_TABLE [12][5] = '{
    '{16'h0061, 16'h0101, 16'h00E1, 16'h01CE, 16'h00E0},
    '{16'h006F, 16'h014D, 16'h00F3, 16'h01D2, 16'h00F2},
    '{16'h0065, 16'h0113, 16'h00E9, 16'h011B, 16'h00E8},
    '{16'h0069, 16'h012B, 16'h00ED, 16'h01D0, 16'h00EC},
    '{16'h0075, 16'h016B, 16'h00FA, 16'h01D4, 16'h00F9},
    '{16'h00FC, 16'h01D6, 16'h01D8, 16'h01DA, 16'h01DC},
    '{16'h0041, 16'h0100, 16'h00C1, 16'h01CD, 16'h00C0},
    '{16'h004F, 16'h014C, 16'h00D3, 16'h01D1, 16'h00D2},
    '{16'h0045, 16'h0112, 16'h00C9, 16'h011A, 16'h00C8},
    '{16'h0049, 16'h012A, 16'h00CD, 16'h01CF, 16'h00CC},
    '{16'h0055, 16'h016A, 16'h00DA, 16'h01D3, 16'h00D9},
    '{16'h00DC, 16'h01D5, 16'h01D7, 16'h01D9, 16'h01DB}
  };

  // rows: first vowel, columns: second vowel, both a o e i u v
  localparam pair_e PAIR_TABLE [6][6] = '{
    '{PAIR_NONE, PAIR_FIRST, PAIR_NONE,   PAIR_FIRST,  PAIR_NONE,   PAIR_NONE},
    '{PAIR_NONE, PAIR_NONE,  PAIR_NONE,   PAIR_NONE,   PAIR_FIRST,  PAIR_NONE},
    '{PAIR_NONE, PAIR_NONE,  PAIR_NONE,   PAIR_FIRST,  PAIR_NONE,   PAIR_NONE},
    '{PAIR_NONE, PAIR_NONE,  PAIR_SECOND, PAIR_NONE,   PAIR_SECOND, PAIR_NONE},
    '{PAIR_NONE, PAIR_NONE,  PAIR_SECOND, PAIR_SECOND, PAIR_NONE,   PAIR_NONE},
    '{PAIR_NONE, PAIR_NONE,  PAIR_NONE,   PAIR_NONE,   PAIR_NONE,   PAIR_NONE}
  };

  function automatic logic [3:0] vowel_index(input logic [CHAR_W-1:0] c);
    logic [3:0] idx;
    unique case (c)
      16'h0061:           idx = 4'd0;
      16'h006F:           idx = 4'd1;
      16'h0065:           idx = 4'd2;
      16'h0069:           idx = 4'd3;
      16'h0075:           idx = 4'd4;
      16'h0076, 16'h00FC: idx = 4'd5;
      16'h0041:           idx = 4'd6;
      16'h004F:           idx = 4'd7;
      16'h0045:           idx = 4'd8;
      16'h0049:           idx = 4'd9;
      16'h0055:           idx = 4'd10;
      16'h0056, 16'h00DC: idx = 4'd11;
      default:            idx = NO_VOWEL;
    endcase
    return idx;
  endfunction

  // fold upper-case rows onto lower-case ones
  function automatic logic [2:0] vowel_row(input logic [3:0] idx);
    logic [3:0] r;
    r = (idx >= 4'd6) ? idx - 4'd6 : idx;
    return r[2:0];
  endfunction

  function automatic pair_e pair_kind(input logic [CHAR_W-1:0] a,
                                      input logic [CHAR_W-1:0] b);
    logic [3:0] ia;
    logic [3:0] ib;
    ia = vowel_index(a);
    ib = vowel_index(b);
    if (ia == NO_VOWEL || ib == NO_VOWEL) begin
      return PAIR_NONE;
    end
    return PAIR_TABLE[vowel_row(ia)][vowel_row(ib)];
  endfunction

  function automatic logic is_n_or_r(input logic [CHAR_W-1:0] c);
    return (c == 16'h004E) || (c == 16'h006E) || (c == 16'h0052) || (c == 16'h0072);
  endfunction

  function automatic logic is_tone_digit(input logic [CHAR_W-1:0] c);
    return (c >= 16'h0030) && (c <= 16'h0034);
  endfunction

  // vowel plus digit to marked code; a non-vowel passes through
  function automatic logic [CHAR_W-1:0] tone_code(input logic [CHAR_W-1:0] vowel,
                                                   input logic [CHAR_W-1:0] digit);
    logic [3:0] idx;
    logic [2:0] col;
    idx = vowel_index(vowel);
    col = digit[2:0];
    if (idx == NO_VOWEL || col > 3'd4) begin
      return vowel;
    end
    return TONE_TABLE[idx][col];
  endfunction

endpackage

FILE: hw/rtl/pinyin_tone_mark_converter.sv
// Top level: stream ports, matcher and two-entry result buffer.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: char_code, tuser: first_of_text
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: replace_position, toned_char,
//                                             remove_position
//
// One character per cycle unless stalled; a result is buffered after its digit.
// The matcher is a single combinational pass in front of a two-entry output buffer.
// Input is held off only while both buffer entries are full.
// Reset clears the match stage, the position counter and the buffer.
module pinyin_tone_mark_converter #(
  parameter int POSITION_BITS = ptm_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ptm_pkg::S_DATA_W-1:0] s_axis_tdata,  // [15:0] char_code
  input  logic                         s_axis_tuser,  // [0] first_of_text
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [31:0] replace_position, [47:32] toned_char, [79:48] remove_position
  output logic [ptm_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import ptm_pkg::*;

  logic        s_accept, push, pop;
  logic        res_valid;
  ptm_result_t res;
  logic [1:0]  count_q, count_d;
  ptm_result_t head_q, head_d, tail_q, tail_d;

  assign s_axis_tready = (count_q != 2'd2);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  ptm_match #(
    .POSITION_BITS(POSITION_BITS)
  ) u_match (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (s_accept),
    .char_code_i    (s_axis_tdata[CHAR_W-1:0]),
    .first_of_text_i(s_axis_tuser),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  assign push = res_valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    unique case (count_q)
      2'd0: begin
        if (push) begin
          head_d  = res;
          count_d = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_d = res;
        end else if (push) begin
          tail_d  = res;
          count_d = 2'd2;
        end else if (pop) begin
          count_d = 2'd0;
        end
      end
      2'd2: begin
        // no push possible here: input is stalled
        if (pop) begin
          head_d  = tail_q;
          count_d = 2'd1;
        end
      end
      default: count_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = head_q;

endmodule

FILE: hw/rtl/ptm_match.sv
// Syllable-tail matcher: position counter, held letters and edit generation.
module ptm_match #(
  parameter int POSITION_BITS = ptm_pkg::POSITION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [ptm_pkg::CHAR_W-1:0] char_code_i,
  input  logic                       first_of_text_i,
  output logic                       res_valid_o,
  output ptm_pkg::ptm_result_t       res_o
);
  import ptm_pkg::*;

  localparam int ExtW = (POSITION_BITS > OUT_POS_W) ? POSITION_BITS : OUT_POS_W;

  stage_e stage_q, stage_d, stage_cur;
  logic [POSITION_BITS-1:0] pos_q, pos_d, pos_cur;
  logic [CHAR_W-1:0] held0_q, held0_d, held1_q, held1_d;

  logic [3:0]        vidx;
  logic              is_vowel, is_digit;
  logic              emit;
  logic [CHAR_W-1:0] emit_vowel;
  logic [1:0]        emit_back;
  logic [POSITION_BITS-1:0] rep_pos;
  logic [ExtW-1:0]   rep_ext, rem_ext;

  assign stage_cur = first_of_text_i ? ST_IDLE : stage_q;
  assign pos_cur   = first_of_text_i ? '0 : pos_q;
  assign vidx      = vowel_index(char_code_i);
  assign is_vowel  = (vidx != NO_VOWEL);
  assign is_digit  = is_tone_digit(char_code_i);

  always_comb begin
    stage_d    = stage_q;
    held0_d    = held0_q;
    held1_d    = held1_q;
    emit       = 1'b0;
    emit_vowel = held0_q;
    emit_back  = 2'd1;
    // restart path: the current character may open a new match
    if (is_vowel) begin
      held0_d = char_code_i;
      stage_d = ST_ONE;
    end else begin
      stage_d = ST_IDLE;
    end
    unique case (stage_cur)
      ST_IDLE: ;
      ST_ONE: begin
        if (is_n_or_r(char_code_i) ||
            (is_vowel && pair_kind(held0_q, char_code_i) != PAIR_NONE)) begin
          held0_d = held0_q;
          held1_d = char_code_i;
          stage_d = ST_TWO;
        end else if (is_digit) begin
          emit    = 1'b1;
          stage_d = ST_IDLE;
        end
      end
      ST_TWO: begin
        if ((char_code_i == 16'h0067 || char_code_i == 16'h0047) &&
            (held1_q == 16'h006E || held1_q == 16'h004E)) begin
          held0_d = held0_q;
          stage_d = ST_THREE;
        end else if (is_digit) begin
          emit    = 1'b1;
          stage_d = ST_IDLE;
          if (is_n_or_r(held1_q) || pair_kind(held0_q, held1_q) == PAIR_FIRST) begin
            emit_back = 2'd2;
          end else begin
            emit_vowel = held1_q;
          end
        end
      end
      ST_THREE: begin
        if (is_digit) begin
          emit      = 1'b1;
          emit_back = 2'd3;
          stage_d   = ST_IDLE;
        end
      end
      default: stage_d = ST_IDLE;
    endcase
  end

  assign pos_d   = pos_cur + POSITION_BITS'(1);
  assign rep_pos = pos_cur - POSITION_BITS'(emit_back);
  assign rep_ext = ExtW'(rep_pos);
  assign rem_ext = ExtW'(pos_cur);

  assign res_valid_o               = accept_i && emit;
  assign res_o.replace_position    = rep_ext[OUT_POS_W-1:0];
  assign res_o.remove_position     = rem_ext[OUT_POS_W-1:0];
  assign res_o.toned_char          = tone_code(emit_vowel, char_code_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_IDLE;
      pos_q   <= '0;
    end else if (accept_i) begin
      stage_q <= stage_d;
      pos_q   <= pos_d;
    end
  end

  // held letters are read only in the stages that wrote them
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held0_q <= held0_d;
      held1_q <= held1_d;
    end
  end

endmodule

FILE: hw/rtl/ptm_checker.sv
// Port-level checks for the converter, bound to the top level.
module ptm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [ptm_pkg::S_DATA_W-1:0] s_axis_tdata,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ptm_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import ptm_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // stalled result holds its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a result only follows an accepted transaction
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_acc))
    else $error("result without input transaction");

  // the first character of a text never yields an edit
  a_first_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("edit from first character");

  // empty output buffer never stalls input
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind pinyin_tone_mark_converter ptm_checker u_ptm_checker (.*);
